>>> design/resource_quota_engine_macros.svh
// assertion macros shared by the quota engine modules
`ifndef RESOURCE_QUOTA_ENGINE_MACROS_SVH
`define RESOURCE_QUOTA_ENGINE_MACROS_SVH

// clocked check, masked while reset is asserted
`define RQE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define RQE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/rqe_pkg.sv
// package with widths, command codes and control types of the quota engine
`default_nettype none

package rqe_pkg;

  localparam int NumResources = 16;
  localparam int IdxW         = $clog2(NumResources);
  localparam int CmdW         = 3;
  localparam int RidxW        = 8;
  localparam int ValW         = 64;

  typedef logic [CmdW-1:0]  cmd_t;
  typedef logic [RidxW-1:0] ridx_t;
  typedef logic [ValW-1:0]  val_t;

  localparam cmd_t CmdSetLimit = 3'd0;
  localparam cmd_t CmdReserve  = 3'd1;
  localparam cmd_t CmdCheck    = 3'd2;
  localparam cmd_t CmdCommit   = 3'd3;
  localparam cmd_t CmdRelease  = 3'd4;
  localparam cmd_t CmdQuery    = 3'd5;

  typedef struct packed {
    logic load;
    logic exec;
    logic eval;
  } rqe_ctrl_t;

endpackage

`default_nettype wire

>>> design/rqe_if.sv
// item channels of the quota engine: command in, result out
`default_nettype none

interface rqe_in_if import rqe_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  ridx_t resource_index;
  val_t  value;

  modport source (output valid, output command, output resource_index, output value,
                  input ready);
  modport sink   (input valid, input command, input resource_index, input value,
                  output ready);
endinterface

interface rqe_out_if import rqe_pkg::*; ();
  logic valid;
  logic ready;
  logic ok;
  logic critical;
  val_t used_now;
  val_t limit_now;

  modport source (output valid, output ok, output critical, output used_now,
                  output limit_now, input ready);
  modport sink   (input valid, input ok, input critical, input used_now,
                  input limit_now, output ready);
endinterface

`default_nettype wire

>>> design/resource_quota_engine.sv
// Top level of the resource quota engine.
// A result is registered in the execute step and then in the evaluate step; out valid rises with the evaluate step.
// A new item is accepted during the evaluate step of the previous one, after its table read-modify-write step;
// a stalled output holds the evaluate step and with it the acceptance of new items.
// Reset: asynchronous, clears usage and limit tables at once, no clearing pass;
// the block is ready for items in the first cycle after reset.
`default_nettype none

module resource_quota_engine import rqe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rqe_in_if.sink    in_i,
  rqe_out_if.source out_o
);

  rqe_ctrl_t ctrl;

  rqe_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctrl_o      (ctrl)
  );

  rqe_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .command_i        (in_i.command),
    .resource_index_i (in_i.resource_index),
    .value_i          (in_i.value),
    .ok_o             (out_o.ok),
    .critical_o       (out_o.critical),
    .used_now_o       (out_o.used_now),
    .limit_now_o      (out_o.limit_now)
  );

endmodule

`default_nettype wire

>>> design/rqe_datapath.sv
// quota tables, command execution and critical evaluation
`default_nettype none

module rqe_datapath import rqe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rqe_ctrl_t ctrl_i,
  input  cmd_t      command_i,
  input  ridx_t     resource_index_i,
  input  val_t      value_i,
  output logic      ok_o,
  output logic      critical_o,
  output val_t      used_now_o,
  output val_t      limit_now_o
);

  cmd_t  op_cmd_q;
  ridx_t op_idx_q;
  val_t  op_val_q;

  val_t usage_q [NumResources];
  val_t limit_q [NumResources];

  logic res_ok_q, res_vld_q;
  val_t res_used_q, res_lim_q;

  logic out_ok_q, out_crit_q;
  val_t out_used_q, out_lim_q;

  logic [IdxW-1:0] tidx;
  logic            idx_ok;
  val_t            cur_used, cur_lim;
  val_t            new_used, new_lim;
  logic            new_ok;
  logic            fits;
  logic [ValW:0]   commit_sum;
  logic [ValW+3:0] nine_lim, ten_used;
  logic            crit;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_cmd_q <= command_i;
      op_idx_q <= resource_index_i;
      op_val_q <= value_i;
    end
  end

  assign tidx     = op_idx_q[IdxW-1:0];
  assign idx_ok   = op_idx_q < RidxW'(NumResources);
  assign cur_used = usage_q[tidx];
  assign cur_lim  = limit_q[tidx];

  assign fits       = (cur_used <= cur_lim) && (op_val_q <= cur_lim - cur_used);
  assign commit_sum = {1'b0, cur_used} + {1'b0, op_val_q};

  always_comb begin
    new_used = cur_used;
    new_lim  = cur_lim;
    new_ok   = 1'b1;
    unique case (op_cmd_q)
      CmdSetLimit: new_lim = op_val_q;
      CmdReserve: begin
        new_ok = fits;
        if (fits) begin
          new_used = cur_used + op_val_q;
        end
      end
      CmdCheck:   new_ok = fits;
      CmdCommit:  new_used = commit_sum[ValW] ? '1 : commit_sum[ValW-1:0];
      CmdRelease: new_used = (op_val_q > cur_used) ? '0 : cur_used - op_val_q;
      CmdQuery:   new_ok = 1'b1;
      default:    new_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumResources; i++) begin
        usage_q[i] <= '0;
        limit_q[i] <= '0;
      end
    end else if (ctrl_i.exec && idx_ok) begin
      usage_q[tidx] <= new_used;
      limit_q[tidx] <= new_lim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      res_vld_q  <= idx_ok;
      res_ok_q   <= idx_ok & new_ok;
      res_used_q <= idx_ok ? new_used : '0;
      res_lim_q  <= idx_ok ? new_lim : '0;
    end
  end

  // headroom of at most limit/10 - 1 is the same as 9*limit + 10 <= 10*usage
  assign nine_lim = {1'b0, res_lim_q, 3'b000} + {4'b0000, res_lim_q} + (ValW+4)'(10);
  assign ten_used = {1'b0, res_used_q, 3'b000} + {3'b000, res_used_q, 1'b0};
  assign crit     = res_vld_q & ((res_lim_q == '0) || (res_used_q >= res_lim_q)
                                 || (nine_lim <= ten_used));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      out_ok_q   <= res_ok_q;
      out_crit_q <= crit;
      out_used_q <= res_used_q;
      out_lim_q  <= res_lim_q;
    end
  end

  assign ok_o        = out_ok_q;
  assign critical_o  = out_crit_q;
  assign used_now_o  = out_used_q;
  assign limit_now_o = out_lim_q;

endmodule

`default_nettype wire

>>> design/rqe_controller.sv
// sequencer of the quota engine: accept, execute, evaluate and output handshake
`default_nettype none

`include "resource_quota_engine_macros.svh"

module rqe_controller import rqe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output rqe_ctrl_t ctrl_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] SEval = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       eval_go;
  logic       accept;

  assign eval_go = !out_valid_q || out_ready_i;
  assign accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = SExec;
        end
      end
      SExec: begin
        ctrl_o.exec = 1'b1;
        state_d     = SEval;
      end
      SEval: begin
        if (eval_go) begin
          ctrl_o.eval = 1'b1;
          in_ready_o  = 1'b1;
          state_d     = in_valid_i ? SExec : SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    ctrl_o.load = in_valid_i && in_ready_o;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.eval) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RQE_ASSERT_RST(a_reset_idle, !rst_ni |-> (state_q == SIdle && !out_valid_q),
                  "not idle in reset")
  `RQE_ASSERT(a_accept_exec, accept |=> state_q == SExec, "accepted item not executed")
  `RQE_ASSERT(a_exec_eval, state_q == SExec |=> (state_q == SEval && !ctrl_o.exec),
              "exec not followed by eval")
  `RQE_ASSERT(a_eval_hold,
              (state_q == SEval && out_valid_q && !out_ready_i) |=>
                (state_q == SEval && out_valid_q),
              "result lost while output stalled")

endmodule

`default_nettype wire
